/* hdl/mer_pkg.sv */
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int unsigned DEC_BITS   = 48;
  localparam int unsigned COLOR_BITS = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INIT,
    PH_R1,
    PH_R2
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_R1T0,
    ST_R1T1,
    ST_R1T2,
    ST_R1U0,
    ST_R1U1,
    ST_R1U2,
    ST_R2I0,
    ST_R2I1,
    ST_R2I2,
    ST_R2I3,
    ST_R2I4,
    ST_R2I5,
    ST_R2CHK,
    ST_R20,
    ST_R21,
    ST_R22,
    ST_EMIT,
    ST_DONE
  } state_e;

endpackage

/* hdl/midpoint_ellipse_rasterizer.sv */
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Axis-aligned midpoint ellipse walk, four mirrored pixels per step item.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser is the opcode (0 loads a new ellipse from tdata,
// 1 advances the walk by one point). Output channel m_axis: one item per pixel,
// tlast on the last pixel of a step, tuser set on the single item that a step
// gives once the walk has ended.
// All decision arithmetic runs through one shared multiplier with a registered
// product, sequenced one product per cycle. Input is taken only while the
// sequencer is idle. Output items given per accepted input item:
//   start item                        no output items
//   step at the start point           4 output items
//   region-one step                   4 output items
//   step that enters region two       4 output items (1 done item at y = 0)
//   region-two step                   4 output items
//   step that ends the walk           1 output item
//   step while no walk is active      1 output item
// Output items leave one per cycle through a single output register; a stall
// of the receiver holds that register and the sequencer until it drains.
// Reset clears the sequencer and leaves no ellipse loaded, so a step gives a
// done item with color zero.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_x, center_y, semi_axis_x, semi_axis_y, color_index
  input  logic [((2*COORD_BITS+2*AXIS_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [((2*COORD_BITS+2+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // last_of_run
  output logic m_axis_tlast,
  // walk_done
  output logic m_axis_tuser
);

  localparam int unsigned OUT_W = ((2*COORD_BITS+2+COLOR_BITS+7)/8)*8;
  localparam int unsigned OFF_W = AXIS_BITS + 1;
  localparam int unsigned PIX_W = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2*AXIS_BITS;
  localparam int unsigned AW    = 2*AXIS_BITS + 5;
  localparam int unsigned BW    = 2*AXIS_BITS;
  localparam int unsigned CY_LO = COORD_BITS;
  localparam int unsigned AX_LO = 2*COORD_BITS;
  localparam int unsigned AY_LO = 2*COORD_BITS + AXIS_BITS;
  localparam int unsigned CL_LO = 2*COORD_BITS + 2*AXIS_BITS;
  localparam int unsigned PAD_W = OUT_W - 2*PIX_W - COLOR_BITS;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [AXIS_BITS-1:0]         ax_q, ax_d, ay_q, ay_d;
  logic [COLOR_BITS-1:0]        col_q, col_d;
  logic [SQ_W-1:0]              a2_q, a2_d, b2_q, b2_d;
  logic [OFF_W-1:0]             x_q, x_d, y_q, y_d;
  logic signed [DEC_BITS-1:0]   dec_q, dec_d, acc_q, acc_d, prod_q;
  logic [1:0]                   k_q, k_d;

  logic                 m_valid_q, m_valid_d;
  logic [OUT_W-1:0]     m_data_q, m_data_d;
  logic                 m_last_q, m_last_d, m_done_q, m_done_d;

  logic signed [AW-1:0]   op_a;
  logic [BW-1:0]          op_b;
  logic signed [AW+BW:0]  mul_full;
  logic signed [DEC_BITS-1:0] twice_prod;

  logic signed [AW-1:0] x_s, y_s;
  logic [OFF_W-1:0]     ym1_abs;
  logic                 in_acc, out_load, r1_cont;
  logic [PIX_W-1:0]     pix_x, pix_y, x_pix, y_pix;
  logic                 x_neg, y_neg;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = !m_valid_q || m_axis_tready;

  assign x_s     = AW'(x_q);
  assign y_s     = AW'(y_q);
  assign ym1_abs = (y_q == '0) ? OFF_W'(1) : y_q - OFF_W'(1);

  assign mul_full   = op_a * $signed({1'b0, op_b});
  assign twice_prod = prod_q <<< 1;
  assign r1_cont    = acc_q > twice_prod;

  assign x_neg = (k_q == 2'd1) || (k_q == 2'd2);
  assign y_neg = k_q[1];
  assign x_pix = PIX_W'(x_q);
  assign y_pix = PIX_W'(y_q);
  assign pix_x = x_neg ? PIX_W'(cx_q) - x_pix : PIX_W'(cx_q) + x_pix;
  assign pix_y = y_neg ? PIX_W'(cy_q) - y_pix : PIX_W'(cy_q) + y_pix;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!s_axis_tuser) begin
            state_d = ST_S0;
          end else begin
            unique case (phase_q)
              PH_INIT: state_d = ST_EMIT;
              PH_R1:   state_d = ST_R1T0;
              PH_R2:   state_d = ST_R2CHK;
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_S0:    state_d = ST_S1;
      ST_S1:    state_d = ST_S2;
      ST_S2:    state_d = ST_S3;
      ST_S3:    state_d = ST_IDLE;
      ST_R1T0:  state_d = ST_R1T1;
      ST_R1T1:  state_d = ST_R1T2;
      ST_R1T2:  state_d = r1_cont ? ST_R1U0 : ST_R2I0;
      ST_R1U0:  state_d = ST_R1U1;
      ST_R1U1:  state_d = ST_R1U2;
      ST_R1U2:  state_d = ST_EMIT;
      ST_R2I0:  state_d = ST_R2I1;
      ST_R2I1:  state_d = ST_R2I2;
      ST_R2I2:  state_d = ST_R2I3;
      ST_R2I3:  state_d = ST_R2I4;
      ST_R2I4:  state_d = ST_R2I5;
      ST_R2I5:  state_d = ST_R2CHK;
      ST_R2CHK: state_d = (y_q == '0) ? ST_DONE : ST_R20;
      ST_R20:   state_d = ST_R21;
      ST_R21:   state_d = ST_R22;
      ST_R22:   state_d = ST_EMIT;
      ST_EMIT:  if (out_load && k_q == 2'd3) state_d = ST_IDLE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d   = phase_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    col_d     = col_q;
    a2_d      = a2_q;
    b2_d      = b2_q;
    x_d       = x_q;
    y_d       = y_q;
    dec_d     = dec_q;
    acc_d     = acc_q;
    k_d       = k_q;
    op_a      = '0;
    op_b      = '0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_done_d  = m_done_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_acc) begin
          if (!s_axis_tuser) begin
            cx_d    = s_axis_tdata[CY_LO-1:0];
            cy_d    = s_axis_tdata[AX_LO-1:CY_LO];
            ax_d    = s_axis_tdata[AY_LO-1:AX_LO];
            ay_d    = s_axis_tdata[CL_LO-1:AY_LO];
            col_d   = s_axis_tdata[CL_LO+COLOR_BITS-1:CL_LO];
            x_d     = '0;
            y_d     = OFF_W'(s_axis_tdata[CL_LO-1:AY_LO]);
            phase_d = PH_INIT;
          end else if (phase_q == PH_INIT) begin
            phase_d = PH_R1;
          end
        end
      end
      ST_S0: begin
        op_a = AW'(ax_q);
        op_b = BW'(ax_q);
      end
      ST_S1: begin
        a2_d = SQ_W'(prod_q);
        op_a = AW'(ay_q);
        op_b = BW'(ay_q);
      end
      ST_S2: begin
        b2_d = SQ_W'(prod_q);
        op_a = AW'(ay_q);
        op_b = a2_q;
      end
      ST_S3: begin
        dec_d = (DEC_BITS'(b2_q) << 2) + DEC_BITS'(a2_q) - (prod_q <<< 2);
      end
      ST_R1T0: begin
        op_a = y_s;
        op_b = a2_q;
      end
      ST_R1T1: begin
        acc_d = (prod_q <<< 1) - DEC_BITS'(a2_q);
        op_a  = x_s + AW'(1);
        op_b  = b2_q;
      end
      ST_R1T2: begin
      end
      ST_R1U0: begin
        op_a = AW'(2) - (y_s <<< 1);
        op_b = a2_q;
      end
      ST_R1U1: begin
        acc_d = prod_q <<< 2;
        op_a  = (x_s <<< 1) + AW'(3);
        op_b  = b2_q;
      end
      ST_R1U2: begin
        x_d = x_q + OFF_W'(1);
        if (dec_q[DEC_BITS-1]) begin
          dec_d = dec_q + (prod_q <<< 2);
        end else begin
          dec_d = dec_q + (prod_q <<< 2) + acc_q;
          y_d   = y_q - OFF_W'(1);
        end
      end
      ST_R2I0: begin
        op_a = (x_s <<< 1) + AW'(1);
        op_b = BW'({x_q, 1'b1});
      end
      ST_R2I1: begin
        op_a = AW'(prod_q);
        op_b = b2_q;
      end
      ST_R2I2: begin
        acc_d = prod_q;
        op_a  = AW'(ym1_abs);
        op_b  = BW'(ym1_abs);
      end
      ST_R2I3: begin
        op_a = AW'(prod_q);
        op_b = a2_q;
      end
      ST_R2I4: begin
        acc_d = acc_q + (prod_q <<< 2);
        op_a  = AW'(b2_q);
        op_b  = a2_q;
      end
      ST_R2I5: begin
        dec_d   = acc_q - (prod_q <<< 2);
        phase_d = PH_R2;
      end
      ST_R2CHK: begin
        if (y_q == '0) phase_d = PH_IDLE;
      end
      ST_R20: begin
        op_a = AW'(3) - (y_s <<< 1);
        op_b = a2_q;
      end
      ST_R21: begin
        acc_d = prod_q <<< 2;
        op_a  = (x_s <<< 1) + AW'(2);
        op_b  = b2_q;
      end
      ST_R22: begin
        y_d = y_q - OFF_W'(1);
        if (dec_q[DEC_BITS-1]) begin
          dec_d = dec_q + acc_q + (prod_q <<< 2);
          x_d   = x_q + OFF_W'(1);
        end else begin
          dec_d = dec_q + acc_q;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, col_q, pix_y, pix_x};
          m_last_d  = (k_q == 2'd3);
          m_done_d  = 1'b0;
          k_d       = k_q + 2'd1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, col_q, {(2*PIX_W){1'b0}}};
          m_last_d  = 1'b1;
          m_done_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_IDLE;
      col_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      col_q     <= col_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    a2_q     <= a2_d;
    b2_q     <= b2_d;
    x_q      <= x_d;
    y_q      <= y_d;
    dec_q    <= dec_d;
    acc_q    <= acc_d;
    prod_q   <= DEC_BITS'(mul_full);
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_done_q <= m_done_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_done_q;

endmodule
